// ----- rtl/core/skt_pkg.sv -----
// skt_pkg: types, codes and defaults shared by the session keepalive table
// no dependencies

package skt_pkg;

  localparam int SlotsDefault = 16;
  localparam int CfgIdxW      = 1;

  localparam logic [7:0] SilenceLimitReset = 8'd10;
  localparam logic [7:0] AckLimitReset     = 8'd2;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_CONNECT    = 3'd1,
    KIND_CONN_REPLY = 3'd2,
    KIND_UPDATE     = 3'd3,
    KIND_UPD_ACK    = 3'd4,
    KIND_CLOSE      = 3'd5,
    KIND_DATA_IN    = 3'd6,
    KIND_SEND_OUT   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ACT_ACCEPT  = 3'd0,
    ACT_CLOSE   = 3'd1,
    ACT_UPDACK  = 3'd2,
    ACT_PROBE   = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_EXPIRED = 3'd5,
    ACT_SEND    = 3'd6,
    ACT_REJECT  = 3'd7
  } action_e;

  typedef enum logic [0:0] {
    CFG_SILENCE_LIMIT = 1'd0,
    CFG_ACK_LIMIT     = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND,
    ST_ALLOC,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] peer_key;
    logic [3:0]  slot_sel;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot_out;
    logic [63:0] key_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       awaiting;
    logic [7:0] ack_left;
    logic [7:0] silence_left;
  } timer_t;

endpackage

// ----- rtl/core/skt_ram.sv -----
// skt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module skt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/session_keepalive_table.sv -----
// session_keepalive_table: sessions keyed by peer identity, keepalive probing on ticks
// item steps: send out reads its slot, then flushes; a scan stops at a hit, else covers all slots;
// a new connect then allocates; one item at a time, set by the single key compare and ram read port
// back-pressure stalls a tick scan with a second result pending, and the last step of any item
// reset clears the in-use bits and loads the limits with 10 and 2; no ram clearing pass
// depends on skt_pkg and skt_ram

module session_keepalive_table #(
  parameter int Slots = skt_pkg::SlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  skt_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output skt_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [skt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  localparam int IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int TmW  = $bits(skt_pkg::timer_t);

  skt_pkg::state_e    state_q, state_d;
  logic [2:0]         kind_q;
  logic [63:0]        key_q;
  logic [3:0]         sel_q;
  logic [IdxW-1:0]    idx_q;
  logic               free_v_q;
  logic [IdxW-1:0]    free_q;
  logic               pend_v_q;
  skt_pkg::out_item_t pend_q;
  logic               out_v_q;
  skt_pkg::out_item_t out_q;
  logic [Slots-1:0]   in_use_q;
  logic [7:0]         sil_lim_q;
  logic [7:0]         ack_lim_q;

  logic [IdxW-1:0]    rd_addr;
  logic [63:0]        key_rd;
  logic [TmW-1:0]     tm_rd_raw;
  skt_pkg::timer_t    tm;
  logic               tm_we;
  logic [IdxW-1:0]    tm_waddr;
  skt_pkg::timer_t    tm_wdata;
  logic               key_we;
  logic               use_set;
  logic               use_clr;
  logic [IdxW-1:0]    use_idx;
  logic               push;
  skt_pkg::out_item_t push_item;
  logic               advance;
  logic               done;
  logic               free_take;
  logic               flush_go;
  logic               can_push;
  logic               live;
  logic               hit;
  logic               is_last;
  logic [3:0]         slot4;
  logic [IdxW-1:0]    sel_idx_in;
  logic [IdxW-1:0]    sel_idx;
  logic               sel_ok;
  logic               in_acc;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == skt_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  assign tm         = skt_pkg::timer_t'(tm_rd_raw);
  assign live       = in_use_q[idx_q];
  assign hit        = live && (key_rd == key_q);
  assign is_last    = (idx_q == IdxW'(Slots - 1));
  assign slot4      = 4'(idx_q);
  assign sel_idx_in = IdxW'(in_item_i.slot_sel);
  assign sel_idx    = IdxW'(sel_q);
  assign sel_ok     = (32'(sel_q) < Slots) && in_use_q[sel_idx];
  assign can_push   = !pend_v_q || !out_v_q || out_ready_i;

  skt_ram #(
    .Width(64),
    .Depth(Slots)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(free_q),
    .wdata_i(key_q),
    .raddr_i(rd_addr),
    .rdata_o(key_rd)
  );

  skt_ram #(
    .Width(TmW),
    .Depth(Slots)
  ) u_timer_ram (
    .clk_i  (clk_i),
    .we_i   (tm_we),
    .waddr_i(tm_waddr),
    .wdata_i(tm_wdata),
    .raddr_i(rd_addr),
    .rdata_o(tm_rd_raw)
  );

  // datapath control
  always_comb begin
    rd_addr   = idx_q;
    tm_we     = 1'b0;
    tm_waddr  = idx_q;
    tm_wdata  = tm;
    key_we    = 1'b0;
    use_set   = 1'b0;
    use_clr   = 1'b0;
    use_idx   = idx_q;
    push      = 1'b0;
    push_item = '0;
    advance   = 1'b0;
    done      = 1'b0;
    free_take = 1'b0;
    flush_go  = 1'b0;
    case (state_q)
      skt_pkg::ST_IDLE: begin
        rd_addr = (in_item_i.kind == skt_pkg::KIND_SEND_OUT) ? sel_idx_in : '0;
      end
      skt_pkg::ST_SCAN: begin
        case (kind_q)
          skt_pkg::KIND_TICK: begin
            if (!live) begin
              advance = 1'b1;
            end else if (tm.awaiting) begin
              if (tm.ack_left <= 8'd1) begin
                if (can_push) begin
                  advance   = 1'b1;
                  push      = 1'b1;
                  push_item = '{action: skt_pkg::ACT_EXPIRED, slot_out: slot4,
                                key_out: key_rd, last: 1'b0};
                  tm_we     = 1'b1;
                  tm_wdata  = '{awaiting: 1'b1, ack_left: 8'd0,
                                silence_left: tm.silence_left};
                  use_clr   = 1'b1;
                end
              end else begin
                advance  = 1'b1;
                tm_we    = 1'b1;
                tm_wdata = '{awaiting: 1'b1, ack_left: tm.ack_left - 8'd1,
                             silence_left: tm.silence_left};
              end
            end else begin
              if (tm.silence_left <= 8'd1) begin
                if (can_push) begin
                  advance   = 1'b1;
                  push      = 1'b1;
                  push_item = '{action: skt_pkg::ACT_PROBE, slot_out: slot4,
                                key_out: key_rd, last: 1'b0};
                  tm_we     = 1'b1;
                  tm_wdata  = '{awaiting: 1'b1, ack_left: tm.ack_left,
                                silence_left: 8'd0};
                end
              end else begin
                advance  = 1'b1;
                tm_we    = 1'b1;
                tm_wdata = '{awaiting: 1'b0, ack_left: tm.ack_left,
                             silence_left: tm.silence_left - 8'd1};
              end
            end
          end
          skt_pkg::KIND_CONNECT: begin
            if (hit) begin
              done      = 1'b1;
              push      = 1'b1;
              push_item = '{action: skt_pkg::ACT_ACCEPT, slot_out: slot4,
                            key_out: key_q, last: 1'b0};
            end else begin
              advance   = 1'b1;
              free_take = !live && !free_v_q;
            end
          end
          skt_pkg::KIND_UPDATE, skt_pkg::KIND_DATA_IN: begin
            if (hit) begin
              done      = 1'b1;
              push      = 1'b1;
              push_item = '{action: (kind_q == skt_pkg::KIND_UPDATE) ?
                                    skt_pkg::ACT_UPDACK : skt_pkg::ACT_DELIVER,
                            slot_out: slot4, key_out: key_q, last: 1'b0};
              tm_we     = 1'b1;
              tm_wdata  = '{awaiting: tm.awaiting, ack_left: tm.ack_left,
                            silence_left: sil_lim_q};
            end else begin
              advance = 1'b1;
              if (is_last) begin
                push      = 1'b1;
                push_item = '{action: skt_pkg::ACT_CLOSE, slot_out: 4'd0,
                              key_out: key_q, last: 1'b0};
              end
            end
          end
          skt_pkg::KIND_UPD_ACK: begin
            if (hit) begin
              done     = 1'b1;
              tm_we    = 1'b1;
              tm_wdata = '{awaiting: 1'b0, ack_left: ack_lim_q, silence_left: sil_lim_q};
            end else begin
              advance = 1'b1;
            end
          end
          skt_pkg::KIND_CLOSE: begin
            if (hit) begin
              done    = 1'b1;
              use_clr = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (advance && !is_last) begin
          rd_addr = idx_q + 1'b1;
        end
      end
      skt_pkg::ST_SEND: begin
        push = 1'b1;
        if (sel_ok) begin
          push_item = '{action: skt_pkg::ACT_SEND, slot_out: sel_q,
                        key_out: key_rd, last: 1'b0};
        end else begin
          push_item = '{action: skt_pkg::ACT_REJECT, slot_out: sel_q,
                        key_out: 64'd0, last: 1'b0};
        end
      end
      skt_pkg::ST_ALLOC: begin
        push = 1'b1;
        if (free_v_q) begin
          key_we    = 1'b1;
          tm_we     = 1'b1;
          tm_waddr  = free_q;
          tm_wdata  = '{awaiting: 1'b0, ack_left: ack_lim_q, silence_left: sil_lim_q};
          use_set   = 1'b1;
          use_idx   = free_q;
          push_item = '{action: skt_pkg::ACT_ACCEPT, slot_out: 4'(free_q),
                        key_out: key_q, last: 1'b0};
        end else begin
          push_item = '{action: skt_pkg::ACT_CLOSE, slot_out: 4'd0,
                        key_out: key_q, last: 1'b0};
        end
      end
      skt_pkg::ST_FLUSH: begin
        flush_go = pend_v_q && (!out_v_q || out_ready_i);
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      skt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_item_i.kind == skt_pkg::KIND_SEND_OUT) ?
                    skt_pkg::ST_SEND : skt_pkg::ST_SCAN;
        end
      end
      skt_pkg::ST_SCAN: begin
        if (done) begin
          state_d = skt_pkg::ST_FLUSH;
        end else if (advance && is_last) begin
          state_d = (kind_q == skt_pkg::KIND_CONNECT) ?
                    skt_pkg::ST_ALLOC : skt_pkg::ST_FLUSH;
        end
      end
      skt_pkg::ST_SEND: begin
        state_d = skt_pkg::ST_FLUSH;
      end
      skt_pkg::ST_ALLOC: begin
        state_d = skt_pkg::ST_FLUSH;
      end
      skt_pkg::ST_FLUSH: begin
        if (!pend_v_q || flush_go) begin
          state_d = skt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = skt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= skt_pkg::ST_IDLE;
      in_use_q  <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      free_v_q  <= 1'b0;
      idx_q     <= '0;
      sil_lim_q <= skt_pkg::SilenceLimitReset;
      ack_lim_q <= skt_pkg::AckLimitReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          skt_pkg::CFG_SILENCE_LIMIT: sil_lim_q <= cfg_data_i;
          skt_pkg::CFG_ACK_LIMIT:     ack_lim_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        idx_q    <= '0;
        free_v_q <= 1'b0;
      end else if (state_q == skt_pkg::ST_SCAN && advance && !is_last) begin
        idx_q <= idx_q + 1'b1;
      end
      if (free_take) begin
        free_v_q <= 1'b1;
      end
      if (use_set) begin
        in_use_q[use_idx] <= 1'b1;
      end
      if (use_clr) begin
        in_use_q[use_idx] <= 1'b0;
      end
      if ((push && pend_v_q) || flush_go) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (push) begin
        pend_v_q <= 1'b1;
      end
      if (flush_go) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_item_i.kind;
      key_q  <= in_item_i.peer_key;
      sel_q  <= in_item_i.slot_sel;
    end
    if (free_take) begin
      free_q <= idx_q;
    end
    if (push) begin
      pend_q <= push_item;
      if (pend_v_q) begin
        out_q <= pend_q;
      end
    end
    if (flush_go) begin
      out_q <= '{action: pend_q.action, slot_out: pend_q.slot_out,
                 key_out: pend_q.key_out, last: 1'b1};
    end
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == skt_pkg::ST_IDLE |-> !pend_v_q)
    else $error("pending item left over while idle");

  a_push_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && pend_v_q |-> !out_v_q || out_ready_i)
    else $error("result pushed while output register is full");

  a_alloc_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == skt_pkg::ST_ALLOC && free_v_q |-> !in_use_q[free_q])
    else $error("allocating a slot that is already in use");
`endif

endmodule

// ----- sim/tb_session_keepalive_table.sv -----
// tb_session_keepalive_table: self-checking testbench for the session keepalive table
// predicts every result from its own copy of the session table and timers and checks
// them in order; depends on skt_pkg and session_keepalive_table
`timescale 1ns / 100ps

module tb_session_keepalive_table;

  localparam int Slots = skt_pkg::SlotsDefault;

  logic                        clk = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready_o;
  skt_pkg::in_item_t           in_item = '0;
  logic                        out_valid_o;
  logic                        out_ready = 1'b0;
  skt_pkg::out_item_t          out_item_o;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready_o;
  logic [skt_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]                  cfg_data = '0;

  // session table copy
  logic        live [Slots];
  logic [63:0] key_tab [Slots];
  logic [7:0]  quiet_left [Slots];
  logic [7:0]  ack_wait_left [Slots];
  logic        probed [Slots];
  logic [7:0]  silence_lim = skt_pkg::SilenceLimitReset;
  logic [7:0]  ack_lim = skt_pkg::AckLimitReset;

  skt_pkg::out_item_t expected_results [$];
  int          mismatches = 0;
  int          rx_hold_cycles = 0;
  int          tx_burst_left = 0;
  int          rx_burst_left = 0;
  logic [63:0] key_pool [20];

  always #4 clk = ~clk;

  session_keepalive_table #(
    .Slots(Slots)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    for (int i = 0; i < Slots; i++) begin
      live[i] = 1'b0;
      key_tab[i] = '0;
      quiet_left[i] = '0;
      ack_wait_left[i] = '0;
      probed[i] = 1'b0;
    end
  end

  function automatic int tx_gap();
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) tx_burst_left = $urandom_range(8, 24);
    return $urandom_range(0, 11);
  endfunction

  function automatic int rx_gap();
    if (rx_burst_left > 0) begin
      rx_burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) rx_burst_left = $urandom_range(8, 24);
    return $urandom_range(0, 11);
  endfunction

  function automatic skt_pkg::in_item_t mk_item(skt_pkg::kind_e k, logic [63:0] key,
                                                logic [3:0] sel);
    skt_pkg::in_item_t it;
    it.kind = k;
    it.peer_key = key;
    it.slot_sel = sel;
    return it;
  endfunction

  function automatic skt_pkg::out_item_t mk_result(skt_pkg::action_e a, int slot,
                                                   logic [63:0] key);
    skt_pkg::out_item_t r;
    r.action = a;
    r.slot_out = 4'(slot);
    r.key_out = key;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int lookup_slot(logic [63:0] key);
    for (int i = 0; i < Slots; i++)
      if (live[i] && key_tab[i] == key) return i;
    return -1;
  endfunction

  // apply one accepted item to the table copy and queue the results it causes
  function automatic void predict_results(skt_pkg::in_item_t it);
    skt_pkg::out_item_t res [$];
    int hit;
    hit = lookup_slot(it.peer_key);
    case (skt_pkg::kind_e'(it.kind))
      skt_pkg::KIND_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (live[i]) begin
            if (probed[i]) begin
              if (ack_wait_left[i] <= 8'd1) begin
                ack_wait_left[i] = '0;
                live[i] = 1'b0;
                res.push_back(mk_result(skt_pkg::ACT_EXPIRED, i, key_tab[i]));
              end else begin
                ack_wait_left[i]--;
              end
            end else if (quiet_left[i] <= 8'd1) begin
              quiet_left[i] = '0;
              probed[i] = 1'b1;
              res.push_back(mk_result(skt_pkg::ACT_PROBE, i, key_tab[i]));
            end else begin
              quiet_left[i]--;
            end
          end
        end
      end
      skt_pkg::KIND_CONNECT: begin
        if (hit < 0) begin
          for (int i = 0; i < Slots; i++) begin
            if (!live[i] && hit < 0) begin
              hit = i;
              live[i] = 1'b1;
              key_tab[i] = it.peer_key;
              quiet_left[i] = silence_lim;
              ack_wait_left[i] = ack_lim;
              probed[i] = 1'b0;
            end
          end
        end
        if (hit < 0) res.push_back(mk_result(skt_pkg::ACT_CLOSE, 0, it.peer_key));
        else res.push_back(mk_result(skt_pkg::ACT_ACCEPT, hit, it.peer_key));
      end
      skt_pkg::KIND_UPDATE, skt_pkg::KIND_DATA_IN: begin
        if (hit < 0) begin
          res.push_back(mk_result(skt_pkg::ACT_CLOSE, 0, it.peer_key));
        end else begin
          quiet_left[hit] = silence_lim;
          res.push_back(mk_result(it.kind == skt_pkg::KIND_UPDATE ?
                                  skt_pkg::ACT_UPDACK : skt_pkg::ACT_DELIVER,
                                  hit, it.peer_key));
        end
      end
      skt_pkg::KIND_UPD_ACK: begin
        if (hit >= 0) begin
          quiet_left[hit] = silence_lim;
          ack_wait_left[hit] = ack_lim;
          probed[hit] = 1'b0;
        end
      end
      skt_pkg::KIND_CLOSE: begin
        if (hit >= 0) live[hit] = 1'b0;
      end
      skt_pkg::KIND_SEND_OUT: begin
        if (int'(it.slot_sel) < Slots && live[it.slot_sel])
          res.push_back(mk_result(skt_pkg::ACT_SEND, it.slot_sel, key_tab[it.slot_sel]));
        else
          res.push_back(mk_result(skt_pkg::ACT_REJECT, it.slot_sel, '0));
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_result(skt_pkg::out_item_t got);
    skt_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected, action", got.action, 0);
      return;
    end
    want = expected_results.pop_front();
    if (got.action !== want.action) report_mismatch("action", got.action, want.action);
    if (got.slot_out !== want.slot_out) report_mismatch("slot_out", got.slot_out, want.slot_out);
    if (got.key_out !== want.key_out) report_mismatch("key_out", got.key_out, want.key_out);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready) check_result(out_item_o);
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid_o && rx_hold_cycles == 0);
    end
  end

  task automatic send_item(skt_pkg::in_item_t it);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready_o);
    predict_results(it);
  endtask

  // sender pauses until every result is back, then lets a full scan finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (Slots + 8) @(posedge clk);
  endtask

  task automatic write_limits(logic [7:0] silence_val, logic [7:0] ack_val);
    cfg_valid <= 1'b1;
    cfg_index <= skt_pkg::CFG_SILENCE_LIMIT;
    cfg_data  <= silence_val;
    do @(posedge clk); while (!cfg_ready_o);
    silence_lim = silence_val;
    cfg_index <= skt_pkg::CFG_ACK_LIMIT;
    cfg_data  <= ack_val;
    do @(posedge clk); while (!cfg_ready_o);
    ack_lim = ack_val;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [63:0] k_lo, k_hi, k_mid, k_none;
    k_lo = '0;
    k_hi = '1;
    k_mid = 64'h0123_4567_89ab_cdef;
    k_none = 64'h5a5a_a5a5_c3c3_3c3c;
    send_item(mk_item(skt_pkg::KIND_TICK, k_hi, 4'hf));
    send_item(mk_item(skt_pkg::KIND_CONNECT, k_lo, 4'h0));
    send_item(mk_item(skt_pkg::KIND_CONNECT, k_hi, 4'hf));
    send_item(mk_item(skt_pkg::KIND_CONNECT, k_lo, 4'h0));
    send_item(mk_item(skt_pkg::KIND_CONN_REPLY, k_mid, 4'h5));
    send_item(mk_item(skt_pkg::KIND_UPDATE, k_hi, 4'ha));
    send_item(mk_item(skt_pkg::KIND_DATA_IN, k_lo, 4'h0));
    send_item(mk_item(skt_pkg::KIND_UPDATE, k_none, 4'h3));
    send_item(mk_item(skt_pkg::KIND_DATA_IN, k_none, 4'hc));
    send_item(mk_item(skt_pkg::KIND_UPD_ACK, k_none, 4'h0));
    send_item(mk_item(skt_pkg::KIND_CLOSE, k_none, 4'h0));
    send_item(mk_item(skt_pkg::KIND_SEND_OUT, k_lo, 4'h1));
    send_item(mk_item(skt_pkg::KIND_SEND_OUT, k_hi, 4'hf));
    send_item(mk_item(skt_pkg::KIND_SEND_OUT, k_lo, 4'h2));
    send_item(mk_item(skt_pkg::KIND_UPD_ACK, k_lo, 4'h0));
    send_item(mk_item(skt_pkg::KIND_CLOSE, k_lo, 4'h0));
    send_item(mk_item(skt_pkg::KIND_SEND_OUT, k_hi, 4'h0));
    send_item(mk_item(skt_pkg::KIND_CONNECT, k_mid, 4'h0));
    send_item(mk_item(skt_pkg::KIND_TICK, k_lo, 4'h0));
    send_item(mk_item(skt_pkg::KIND_SEND_OUT, k_lo, 4'h0));
    send_item(mk_item(skt_pkg::KIND_CLOSE, k_hi, 4'h0));
    send_item(mk_item(skt_pkg::KIND_CLOSE, k_mid, 4'h0));
    wait_idle();
  endtask

  // result side held off while connects keep coming: the table fills and input stalls
  task automatic test_fill_backpressure();
    write_limits(8'd1, 8'd3);
    rx_hold_cycles = 600;
    for (int i = 0; i < Slots + 2; i++)
      send_item(mk_item(skt_pkg::KIND_CONNECT, {$urandom, $urandom}, 4'($urandom)));
    wait_idle();
  endtask

  task automatic test_keepalive_timers();
    send_item(mk_item(skt_pkg::KIND_TICK, '0, 4'h0));
    send_item(mk_item(skt_pkg::KIND_TICK, '1, 4'hf));
    send_item(mk_item(skt_pkg::KIND_UPD_ACK, key_tab[5], 4'h5));
    send_item(mk_item(skt_pkg::KIND_TICK, '0, 4'h0));
    send_item(mk_item(skt_pkg::KIND_TICK, '0, 4'h0));
    wait_idle();
    write_limits(8'd0, 8'd0);
    send_item(mk_item(skt_pkg::KIND_CONNECT, 64'hfeed_0000_0000_0001, 4'h0));
    send_item(mk_item(skt_pkg::KIND_TICK, '0, 4'h0));
    send_item(mk_item(skt_pkg::KIND_TICK, '0, 4'h0));
    send_item(mk_item(skt_pkg::KIND_TICK, '0, 4'h0));
    wait_idle();
  endtask

  function automatic skt_pkg::in_item_t random_item();
    skt_pkg::in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.slot_sel = 4'($urandom);
    if ($urandom_range(0, 6) == 0) it.peer_key = {$urandom, $urandom};
    else it.peer_key = key_pool[$urandom_range(0, 19)];
    if (r < 15) it.kind = skt_pkg::KIND_TICK;
    else if (r < 35) it.kind = skt_pkg::KIND_CONNECT;
    else if (r < 38) it.kind = skt_pkg::KIND_CONN_REPLY;
    else if (r < 53) it.kind = skt_pkg::KIND_UPDATE;
    else if (r < 65) it.kind = skt_pkg::KIND_UPD_ACK;
    else if (r < 73) it.kind = skt_pkg::KIND_CLOSE;
    else if (r < 88) it.kind = skt_pkg::KIND_DATA_IN;
    else it.kind = skt_pkg::KIND_SEND_OUT;
    return it;
  endfunction

  task automatic test_random_traffic(int n_items);
    logic [7:0] sil_set [6];
    logic [7:0] ack_set [6];
    sil_set = '{8'd255, 8'd2, 8'd1, 8'd0, 8'd3, 8'd10};
    ack_set = '{8'd255, 8'd1, 8'd4, 8'd3, 8'd2, 8'd2};
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph == 4) write_limits(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
      else write_limits(sil_set[ph], ack_set[ph]);
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 20; i++) key_pool[i] = {$urandom, $urandom};
      for (int i = 0; i < n_items / 6; i++) send_item(random_item());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_backpressure();
    test_keepalive_timers();
    test_random_traffic(282);
    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[session_keepalive_table] OK");
    end else begin
      $display("[session_keepalive_table] ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[session_keepalive_table] ERROR");
    $finish;
  end

endmodule
